// ----- hw/rtl/msc_pkg.sv -----
// shared codes and control types for the msi snooping cache controller
package msc_pkg;

  localparam int ADDR_W = 32;

  // request kinds
  localparam logic [2:0] KIND_PROC_RD  = 3'd0;
  localparam logic [2:0] KIND_PROC_WR  = 3'd1;
  localparam logic [2:0] KIND_SNOOP_RD = 3'd2;
  localparam logic [2:0] KIND_SNOOP_RDX = 3'd3;
  localparam logic [2:0] KIND_SNOOP_FLUSH = 3'd4;

  // bus operations
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_RD    = 2'd1;
  localparam logic [1:0] OP_RDX   = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  // line states
  localparam logic [1:0] LS_INV = 2'd0;
  localparam logic [1:0] LS_SHR = 2'd1;
  localparam logic [1:0] LS_MOD = 2'd2;

  typedef struct packed {
    logic capture;
    logic commit;
    logic clear;
  } msc_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_room;
  } msc_status_t;

endpackage

// ----- hw/rtl/msc_ram.sv -----
// generic single-write, single-read ram with registered read data
module msc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/msc_ctrl.sv -----
// controller state machine: state clearing, request capture, lookup and commit
module msc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  msc_pkg::msc_status_t status_i,
  output msc_pkg::msc_cmd_t    cmd_o
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.clear   = (state_q == ST_CLEAR);
  assign cmd_o.capture = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.commit  = (state_q == ST_LOOKUP) && status_i.out_room;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        // hold until the result buffer can take both results
        if (status_i.out_room) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && status_i.clear_done) |=> (state_q == ST_IDLE))
    else $error("clearing pass did not hand over to idle");

endmodule

// ----- hw/rtl/msc_dp.sv -----
// datapath: tag and state rams, hit and victim logic, result buffer
module msc_dp #(
  parameter int LINE_BYTES = 32,
  parameter int SETS       = 64,
  parameter int WAYS       = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  msc_pkg::msc_cmd_t          cmd_i,
  output msc_pkg::msc_status_t       status_o,
  input  logic [2:0]                 kind_i,
  input  logic [msc_pkg::ADDR_W-1:0] address_i,
  input  logic [1:0]                 victim_way_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 bus_op_o,
  output logic [msc_pkg::ADDR_W-1:0] bus_address_o,
  output logic                       hit_o,
  output logic                       last_o
);

  localparam int OFF_W    = $clog2(LINE_BYTES);
  localparam int SET_BITS = $clog2(SETS);
  localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_W    = msc_pkg::ADDR_W - OFF_W - SET_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef struct packed {
    logic [1:0]                 op;
    logic [msc_pkg::ADDR_W-1:0] addr;
    logic                       hit;
    logic                       last;
  } msc_res_t;

  // captured request
  logic [2:0]                 kind_q;
  logic [msc_pkg::ADDR_W-1:0] addr_q;
  logic [1:0]                 vway_q;
  logic [IDX_W-1:0]           set_q;
  logic [TAG_W-1:0]           tag_q;
  logic [IDX_W-1:0]           set_in;

  // ram ports
  logic [WAYS*2-1:0]     st_rdata, st_wdata, st_new_row;
  logic [WAYS*TAG_W-1:0] tag_rdata, tag_new_row;
  logic                  st_we, tag_we;
  logic [IDX_W-1:0]      st_waddr;

  // clearing pass
  logic [IDX_W-1:0] clr_q;
  logic             clr_last;

  // lookup
  logic [1:0]       st_w   [WAYS];
  logic [TAG_W-1:0] tg_w   [WAYS];
  logic [1:0]       st_new [WAYS];
  logic [WAYS-1:0]  match, free;
  logic [WAY_W-1:0] hit_way, free_way, vmod, ins_way;
  logic             is_proc, is_wr, any_hit, any_free, snoop_flush, two_res, tag_wr_en;
  logic [1:0]       fill_st;
  msc_res_t         res0, res1;

  // result buffer
  msc_res_t buf0_q, buf1_q;
  logic [1:0] cnt_q;
  logic       deq, room;

  function automatic logic [msc_pkg::ADDR_W-1:0] blk_addr(input logic [TAG_W-1:0] t,
                                                         input logic [IDX_W-1:0] s);
    logic [msc_pkg::ADDR_W-1:0] a;
    a = msc_pkg::ADDR_W'(t) << (SET_BITS + OFF_W);
    if (SET_BITS > 0) a = a | (msc_pkg::ADDR_W'(s) << OFF_W);
    return a;
  endfunction

  assign set_in = (SET_BITS > 0) ? address_i[OFF_W +: IDX_W] : '0;
  assign tag_q  = addr_q[msc_pkg::ADDR_W-1 -: TAG_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      addr_q <= address_i;
      vway_q <= victim_way_i;
      set_q  <= set_in;
    end
  end

  // clearing pass over the state ram, one set per cycle
  assign clr_last = (clr_q == IDX_W'(SETS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear && !clr_last) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign st_we    = cmd_i.clear || cmd_i.commit;
  assign st_waddr = cmd_i.clear ? clr_q : set_q;
  assign st_wdata = cmd_i.clear ? '0 : st_new_row;
  assign tag_we   = cmd_i.commit && tag_wr_en;

  msc_ram #(.WIDTH(WAYS * 2), .DEPTH(SETS)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (set_in),
    .rdata_o (st_rdata)
  );

  msc_ram #(.WIDTH(WAYS * TAG_W), .DEPTH(SETS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (set_q),
    .wdata_i (tag_new_row),
    .re_i    (cmd_i.capture),
    .raddr_i (set_in),
    .rdata_o (tag_rdata)
  );

  // victim way taken modulo the way count
  always_comb begin
    unique case (vway_q)
      2'd0: vmod = WAY_W'(0 % WAYS);
      2'd1: vmod = WAY_W'(1 % WAYS);
      2'd2: vmod = WAY_W'(2 % WAYS);
      default: vmod = WAY_W'(3 % WAYS);
    endcase
  end

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      st_w[w]  = st_rdata[w*2 +: 2];
      tg_w[w]  = tag_rdata[w*TAG_W +: TAG_W];
      match[w] = (st_w[w] != msc_pkg::LS_INV) && (tg_w[w] == tag_q);
      free[w]  = (st_w[w] == msc_pkg::LS_INV);
    end
    // lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
      if (free[w]) free_way = WAY_W'(w);
    end
  end

  assign any_hit  = |match;
  assign any_free = |free;
  assign is_proc  = (kind_q == msc_pkg::KIND_PROC_RD) || (kind_q == msc_pkg::KIND_PROC_WR);
  assign is_wr    = (kind_q == msc_pkg::KIND_PROC_WR);
  assign fill_st  = is_wr ? msc_pkg::LS_MOD : msc_pkg::LS_SHR;
  assign ins_way  = any_free ? free_way : vmod;

  always_comb begin
    for (int w = 0; w < WAYS; w++) st_new[w] = st_w[w];
    tag_new_row = tag_rdata;
    tag_wr_en   = 1'b0;
    snoop_flush = 1'b0;
    two_res     = 1'b0;
    res0        = '{op: msc_pkg::OP_NONE, addr: '0, hit: 1'b0, last: 1'b1};
    res1        = '{op: msc_pkg::OP_NONE, addr: '0, hit: 1'b0, last: 1'b1};
    if (is_proc) begin
      if (any_hit) begin
        res0.hit = 1'b1;
        if (is_wr && st_w[hit_way] != msc_pkg::LS_MOD) begin
          res0.op         = msc_pkg::OP_RDX;
          res0.addr       = addr_q;
          st_new[hit_way] = msc_pkg::LS_MOD;
        end
      end else begin
        res0.op   = is_wr ? msc_pkg::OP_RDX : msc_pkg::OP_RD;
        res0.addr = addr_q;
        // modified victim is written back as the second result
        if (!any_free && st_w[vmod] == msc_pkg::LS_MOD) begin
          two_res   = 1'b1;
          res0.last = 1'b0;
          res1.op   = msc_pkg::OP_FLUSH;
          res1.addr = blk_addr(tg_w[vmod], set_q);
        end
        tag_wr_en = 1'b1;
        for (int w = 0; w < WAYS; w++) begin
          if (WAY_W'(w) == ins_way) begin
            st_new[w]                      = fill_st;
            tag_new_row[w*TAG_W +: TAG_W] = tag_q;
          end
        end
      end
    end else if (kind_q == msc_pkg::KIND_SNOOP_RD || kind_q == msc_pkg::KIND_SNOOP_RDX) begin
      for (int w = 0; w < WAYS; w++) begin
        if (match[w]) begin
          if (st_w[w] == msc_pkg::LS_MOD) begin
            snoop_flush = 1'b1;
            st_new[w]   = (kind_q == msc_pkg::KIND_SNOOP_RD) ? msc_pkg::LS_SHR
                                                             : msc_pkg::LS_INV;
          end else if (kind_q == msc_pkg::KIND_SNOOP_RDX) begin
            st_new[w] = msc_pkg::LS_INV;
          end
        end
      end
      if (snoop_flush) begin
        res0.op   = msc_pkg::OP_FLUSH;
        res0.addr = blk_addr(tag_q, set_q);
      end
    end
    for (int w = 0; w < WAYS; w++) st_new_row[w*2 +: 2] = st_new[w];
  end

  // two-entry result buffer
  assign deq  = (cnt_q != 2'd0) && out_ready_i;
  assign room = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (cmd_i.commit) begin
      cnt_q <= two_res ? 2'd2 : 2'd1;
    end else if (deq) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      buf0_q <= res0;
      buf1_q <= res1;
    end else if (deq) begin
      buf0_q <= buf1_q;
    end
  end

  assign status_o.clear_done = clr_last;
  assign status_o.out_room   = room;

  assign out_valid_o   = (cnt_q != 2'd0);
  assign bus_op_o      = buf0_q.op;
  assign bus_address_o = buf0_q.addr;
  assign hit_o         = buf0_q.hit;
  assign last_o        = buf0_q.last;

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> $onehot0(match))
    else $error("tag present in more than one way of a set");

  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> room)
    else $error("lookup committed over pending results");

  a_snoop_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !is_proc) |-> !two_res)
    else $error("snoop produced a second result");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

endmodule

// ----- hw/rtl/msi_snooping_cache_controller.sv -----
// top level of the msi snooping cache controller
//
//  channel   handshake                  payload
//  request   in_valid_i / in_ready_o    kind_i, address_i, victim_way_i
//  result    out_valid_o / out_ready_i  bus_op_o, bus_address_o, hit_o, last_o
//
// a request is first captured with the set read of the tag and state rams, then resolved in
// the lookup state: hit/victim choice and write-back into the state ram and, on a fill, the tag ram.
// a request with two results holds the next lookup until the result buffer drains.
// after reset the state ram is cleared one set per cycle, and no requests are taken meanwhile.
// stalls on the result side back up through the two-entry result buffer only.
module msi_snooping_cache_controller #(
  parameter int LINE_BYTES = 32,
  parameter int SETS       = 64,
  parameter int WAYS       = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 kind_i,
  input  logic [msc_pkg::ADDR_W-1:0] address_i,
  input  logic [1:0]                 victim_way_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 bus_op_o,
  output logic [msc_pkg::ADDR_W-1:0] bus_address_o,
  output logic                       hit_o,
  output logic                       last_o
);

  msc_pkg::msc_cmd_t    cmd;
  msc_pkg::msc_status_t status;

  msc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  msc_dp #(
    .LINE_BYTES (LINE_BYTES),
    .SETS       (SETS),
    .WAYS       (WAYS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .kind_i        (kind_i),
    .address_i     (address_i),
    .victim_way_i  (victim_way_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bus_op_o      (bus_op_o),
    .bus_address_o (bus_address_o),
    .hit_o         (hit_o),
    .last_o        (last_o)
  );

endmodule

// ----- tb/sv/tb_msi_snooping_cache_controller.sv -----
// self-checking testbench for the msi snooping cache controller: directed and random requests
`timescale 1ns / 100ps

typedef struct {
  logic [1:0]  op;
  logic [31:0] addr;
  logic        hit;
  logic        last;
} bus_result_t;

class coherence_scoreboard;
  localparam int WAYS  = 4;
  localparam int LINES = 256;

  logic [1:0]  line_state [LINES];
  logic [20:0] line_tag   [LINES];
  bus_result_t bus_result_q [$];
  int          n_requests;
  int          n_results;
  int          n_flushes;
  int          n_hits;
  int          errors;

  function new();
    foreach (line_state[i]) line_state[i] = msc_pkg::LS_INV;
    foreach (line_tag[i]) line_tag[i] = '0;
    n_requests = 0;
    n_results  = 0;
    n_flushes  = 0;
    n_hits     = 0;
    errors     = 0;
  endfunction

  function automatic bus_result_t make_result(logic [1:0] op, logic [31:0] addr, logic hit);
    bus_result_t r;
    r.op   = op;
    r.addr = addr;
    r.hit  = hit;
    r.last = 1'b0;
    return r;
  endfunction

  // work out the bus requests one accepted request causes and update the line states
  function void note_request(logic [2:0] kind, logic [31:0] addr, logic [1:0] vway);
    bus_result_t res [$];
    logic [5:0]  set_ix;
    logic [20:0] tg;
    logic [1:0]  new_state;
    int          base;
    int          found;
    int          free_way;
    int          ix;
    set_ix = addr[10:5];
    tg     = addr[31:11];
    base   = int'(set_ix) * WAYS;
    n_requests++;
    case (kind)
      msc_pkg::KIND_PROC_RD, msc_pkg::KIND_PROC_WR: begin
        found = -1;
        for (int w = 0; w < WAYS; w++) begin
          if (found < 0 && line_state[base+w] != msc_pkg::LS_INV && line_tag[base+w] == tg)
            found = w;
        end
        if (found >= 0) begin
          ix = base + found;
          n_hits++;
          if (kind == msc_pkg::KIND_PROC_WR && line_state[ix] != msc_pkg::LS_MOD) begin
            res.push_back(make_result(msc_pkg::OP_RDX, addr, 1'b1));
            line_state[ix] = msc_pkg::LS_MOD;
          end else begin
            res.push_back(make_result(msc_pkg::OP_NONE, '0, 1'b1));
          end
        end else begin
          new_state = (kind == msc_pkg::KIND_PROC_WR) ? msc_pkg::LS_MOD : msc_pkg::LS_SHR;
          res.push_back(make_result((kind == msc_pkg::KIND_PROC_WR) ? msc_pkg::OP_RDX
                                                                    : msc_pkg::OP_RD,
                                    addr, 1'b0));
          free_way = -1;
          for (int w = 0; w < WAYS; w++) begin
            if (free_way < 0 && line_state[base+w] == msc_pkg::LS_INV) free_way = w;
          end
          if (free_way >= 0) begin
            ix = base + free_way;
          end else begin
            ix = base + (int'(vway) % WAYS);
            // dirty victim goes back to memory after the fill request
            if (line_state[ix] == msc_pkg::LS_MOD)
              res.push_back(make_result(msc_pkg::OP_FLUSH, {line_tag[ix], set_ix, 5'b0},
                                        1'b0));
          end
          line_tag[ix]   = tg;
          line_state[ix] = new_state;
        end
      end
      msc_pkg::KIND_SNOOP_RD, msc_pkg::KIND_SNOOP_RDX: begin
        for (int w = 0; w < WAYS; w++) begin
          ix = base + w;
          if (line_state[ix] != msc_pkg::LS_INV && line_tag[ix] == tg) begin
            if (line_state[ix] == msc_pkg::LS_MOD) begin
              if (res.size() < 2)
                res.push_back(make_result(msc_pkg::OP_FLUSH, {tg, set_ix, 5'b0}, 1'b0));
              line_state[ix] = (kind == msc_pkg::KIND_SNOOP_RD) ? msc_pkg::LS_SHR
                                                                : msc_pkg::LS_INV;
            end else if (kind == msc_pkg::KIND_SNOOP_RDX) begin
              line_state[ix] = msc_pkg::LS_INV;
            end
          end
        end
        if (res.size() == 0) res.push_back(make_result(msc_pkg::OP_NONE, '0, 1'b0));
      end
      default: begin
        res.push_back(make_result(msc_pkg::OP_NONE, '0, 1'b0));
      end
    endcase
    res[res.size()-1].last = 1'b1;
    foreach (res[i]) bus_result_q.push_back(res[i]);
  endfunction

  function void check_result(logic [1:0] op, logic [31:0] addr, logic hit, logic last);
    bus_result_t e;
    n_results++;
    if (bus_result_q.size() == 0) begin
      $error("unexpected result: bus_op %0d bus_address %h hit %0d last %0d",
             op, addr, hit, last);
      errors++;
      return;
    end
    e = bus_result_q.pop_front();
    if (op == msc_pkg::OP_FLUSH) n_flushes++;
    if (op !== e.op) begin
      $error("bus_op: expected %0d, actual %0d", e.op, op);
      errors++;
    end
    if (addr !== e.addr) begin
      $error("bus_address: expected %h, actual %h", e.addr, addr);
      errors++;
    end
    if (hit !== e.hit) begin
      $error("hit: expected %0d, actual %0d", e.hit, hit);
      errors++;
    end
    if (last !== e.last) begin
      $error("last: expected %0d, actual %0d", e.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return bus_result_q.size();
  endfunction
endclass

module tb_msi_snooping_cache_controller;

  localparam logic [2:0] KIND_RSVD_5 = 3'd5;
  localparam logic [2:0] KIND_RSVD_6 = 3'd6;
  localparam logic [2:0] KIND_RSVD_7 = 3'd7;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [2:0]  kind_i       = msc_pkg::KIND_PROC_RD;
  logic [31:0] address_i    = '0;
  logic [1:0]  victim_way_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [1:0]  bus_op_o;
  logic [31:0] bus_address_o;
  logic        hit_o;
  logic        last_o;

  coherence_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;

  // a few hot sets and more tags than ways keep hits, evictions and snoop matches frequent
  logic [5:0]  hot_sets [4] = '{6'd0, 6'd63, 6'd21, 6'd42};
  logic [20:0] hot_tags [6] = '{21'h000000, 21'h1FFFFF, 21'h0AAAAA, 21'h155555,
                                21'h000005, 21'h000006};

  msi_snooping_cache_controller DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .address_i     (address_i),
    .victim_way_i  (victim_way_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bus_op_o      (bus_op_o),
    .bus_address_o (bus_address_o),
    .hit_o         (hit_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_request(input logic [2:0] k, input logic [31:0] a, input logic [1:0] v);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    address_i    <= a;
    victim_way_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(k, a, v);
  endtask

  function automatic logic [2:0] pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 35) return msc_pkg::KIND_PROC_RD;
    if (r < 65) return msc_pkg::KIND_PROC_WR;
    if (r < 77) return msc_pkg::KIND_SNOOP_RD;
    if (r < 89) return msc_pkg::KIND_SNOOP_RDX;
    if (r < 95) return msc_pkg::KIND_SNOOP_FLUSH;
    if (r < 97) return KIND_RSVD_5;
    if (r < 98) return KIND_RSVD_6;
    return KIND_RSVD_7;
  endfunction

  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    a = $urandom();
    if ($urandom_range(99) >= 10) begin
      a[10:5]  = hot_sets[$urandom_range(3)];
      a[31:11] = hot_tags[$urandom_range(5)];
    end
    return a;
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_request(pick_kind(), pick_address(), 2'($urandom_range(3)));
  endtask

  // result side: check at each edge, then choose ready for the next cycle
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(bus_op_o, bus_address_o, hit_o, last_o);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("tb_msi_snooping_cache_controller: errors");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fills, upgrades, evictions and snoops in set 0, then the top of memory
    send_request(msc_pkg::KIND_PROC_RD, 32'h0000_0000, 2'd0);
    send_request(msc_pkg::KIND_PROC_RD, 32'h0000_0000, 2'd0);
    send_request(msc_pkg::KIND_PROC_WR, 32'h0000_0000, 2'd0);
    send_request(msc_pkg::KIND_PROC_WR, 32'h0000_0004, 2'd0);
    send_request(msc_pkg::KIND_PROC_WR, 32'h0000_0800, 2'd0);
    send_request(msc_pkg::KIND_PROC_RD, 32'h0000_1000, 2'd0);
    send_request(msc_pkg::KIND_PROC_RD, 32'h0000_1800, 2'd0);
    send_request(msc_pkg::KIND_PROC_RD, 32'h0000_2000, 2'd0);
    send_request(msc_pkg::KIND_PROC_RD, 32'h0000_2800, 2'd2);
    send_request(msc_pkg::KIND_SNOOP_RD, 32'h0000_0800, 2'd0);
    send_request(msc_pkg::KIND_SNOOP_RDX, 32'h0000_0800, 2'd0);
    send_request(msc_pkg::KIND_PROC_WR, 32'h0000_3000, 2'd1);
    send_request(msc_pkg::KIND_SNOOP_RDX, 32'h0000_3000, 2'd0);
    send_request(msc_pkg::KIND_SNOOP_FLUSH, 32'h0000_1800, 2'd0);
    send_request(msc_pkg::KIND_PROC_WR, 32'hFFFF_FFFF, 2'd3);
    send_request(msc_pkg::KIND_SNOOP_RD, 32'hFFFF_FFE0, 2'd3);
    send_request(msc_pkg::KIND_PROC_RD, 32'hFFFF_FFFF, 2'd3);
    send_request(msc_pkg::KIND_PROC_WR, 32'hFFFF_FFFF, 2'd3);
    send_request(KIND_RSVD_5, 32'hFFFF_FFFF, 2'd3);
    send_request(KIND_RSVD_6, 32'h0000_0000, 2'd0);
    send_request(KIND_RSVD_7, 32'hFFFF_FFFF, 2'd3);

    send_random(300);
    send_idle_pct = 58;
    send_random(300);
    send_idle_pct  = 0;
    recv_stall_pct = 58;
    send_random(300);
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    send_random(300);

    // long receiver hold while requests keep coming, so the result buffer fills
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 400;
    send_random(100);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d requests under several idle and stall mixes, one long result hold",
             sb.n_requests);
    $display("checked %0d bus results: %0d flushes, %0d processor hits",
             sb.n_results, sb.n_flushes, sb.n_hits);
    if (sb.errors == 0) begin
      $display("tb_msi_snooping_cache_controller: clean");
    end else begin
      $display("tb_msi_snooping_cache_controller: errors");
    end
    $finish;
  end

endmodule
